// ===== rtl/core/first_fit_heap_allocator_defines.svh =====
// Assertion helpers for the first-fit heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define FFHA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha check failed");

// Next-cycle implication, masked during reset.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants, types and status codes shared by the heap allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;

  localparam int ArenaBytes  = 4096;
  localparam int HeaderBytes = 24;
  localparam int AlignBytes  = 8;
  localparam int Units       = ArenaBytes / AlignBytes;   // 512
  localparam int HdrUnits    = HeaderBytes / AlignBytes;  // 3
  localparam int UNIT_W      = 9;   // index of one unit
  localparam int CUR_W       = 10;  // unit position incl. arena end
  localparam int NEED_W      = 10;  // padded request in units

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_MEM     = 3'd2;
  localparam logic [2:0] ST_NULL_PTR   = 3'd3;
  localparam logic [2:0] ST_BAD_PTR    = 3'd4;
  localparam logic [2:0] ST_DOUBLE     = 3'd5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // one chunk header: payload size held in units
  typedef struct packed {
    logic              hdr;
    logic              free;
    logic [UNIT_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [UNIT_W-1:0] waddr;
    entry_t            wdata;
    logic [UNIT_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_mem
// Chunk header store, one entry per alignment unit, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_mem
  import ffha_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rdata
);

  entry_t mem [Units];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Chain walker: read a header, check, write back split or merged headers.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [11:0] req_size,
  input  wire logic        null_pointer,
  input  wire logic [11:0] free_offset,
  input  wire logic        slot_free,
  output logic             res_valid,
  output logic [2:0]       res_status,
  output logic [11:0]      res_offset,
  output mem_req_t         mreq,
  input  wire entry_t      rdata
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_AREQ = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_AWR  = 4'd4;
  localparam logic [3:0] S_FREQ = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_NREQ = 4'd7;
  localparam logic [3:0] S_NCHK = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  logic [3:0]        state, state_next;
  logic [CUR_W-1:0]  cur, cur_next;
  logic [NEED_W-1:0] need, need_next;
  logic [UNIT_W-1:0] target, target_next;
  logic              has_prev, has_prev_next;
  logic              prev_free, prev_free_next;
  logic [UNIT_W-1:0] prev_u, prev_u_next;
  logic [UNIT_W-1:0] prev_pay, prev_pay_next;
  logic [UNIT_W-1:0] cur_pay, cur_pay_next;
  logic [2:0]        status, status_next;
  logic [11:0]       offset, offset_next;

  logic [12:0]       pad_sum;
  logic [CUR_W-1:0]  walk_next;
  logic [UNIT_W-1:0] cpay;
  logic              nx_free;
  logic [UNIT_W-1:0] nx_pay;
  logic              take_prev;
  logic [CUR_W+1:0]  merged;

  assign pad_sum   = 13'(req_size) + 13'(HeaderBytes + AlignBytes - 1);
  assign walk_next = cur + CUR_W'(HdrUnits) + CUR_W'(rdata.size);
  assign take_prev = has_prev && prev_free;

  // merged payload of the freed chunk and its free neighbours
  always_comb begin
    merged = (CUR_W+2)'(cpay);
    if (take_prev) begin
      merged = merged + (CUR_W+2)'(prev_pay) + (CUR_W+2)'(HdrUnits);
    end
    if (nx_free) begin
      merged = merged + (CUR_W+2)'(nx_pay) + (CUR_W+2)'(HdrUnits);
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    need_next      = need;
    target_next    = target;
    has_prev_next  = has_prev;
    prev_free_next = prev_free;
    prev_u_next    = prev_u;
    prev_pay_next  = prev_pay;
    cur_pay_next   = cur_pay;
    status_next    = status;
    offset_next    = offset;
    mreq           = '0;
    mreq.raddr     = cur[UNIT_W-1:0];
    cpay           = cur_pay;
    nx_free        = 1'b0;
    nx_pay         = rdata.size;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    unique case (state)
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = '{hdr: 1'b1, free: 1'b1, size: UNIT_W'(Units - HdrUnits)};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_next      = '0;
          has_prev_next = 1'b0;
          offset_next   = '0;
          status_next   = ST_OK;
          need_next     = NEED_W'((pad_sum >> 3) - 13'(HdrUnits));
          target_next   = UNIT_W'((free_offset >> 3) - 12'(HdrUnits));
          if (cmd == CMD_ALLOC) begin
            if (req_size == '0) begin
              status_next = ST_ZERO_SIZE;
              state_next  = S_RESP;
            end else begin
              state_next = S_AREQ;
            end
          end else if (null_pointer) begin
            status_next = ST_NULL_PTR;
            state_next  = S_RESP;
          end else if (free_offset < 12'(HeaderBytes) || free_offset[2:0] != 3'd0) begin
            // below the first payload or off the unit grid: matches no chunk
            status_next = ST_BAD_PTR;
            state_next  = S_RESP;
          end else begin
            state_next = S_FREQ;
          end
        end
      end
      S_AREQ: state_next = S_ACHK;
      S_ACHK: begin
        if (rdata.free && NEED_W'(rdata.size) >= need) begin
          offset_next = {UNIT_W'(cur + CUR_W'(HdrUnits)), 3'b000};
          if (NEED_W'(rdata.size) >= need + NEED_W'(HdrUnits + 1)) begin
            // split: new free header right after the granted payload
            mreq.we         = 1'b1;
            mreq.waddr      = UNIT_W'(cur + CUR_W'(HdrUnits) + need);
            mreq.wdata.hdr  = 1'b1;
            mreq.wdata.free = 1'b1;
            mreq.wdata.size = UNIT_W'(NEED_W'(rdata.size) - need - NEED_W'(HdrUnits));
            state_next      = S_AWR;
          end else begin
            mreq.we         = 1'b1;
            mreq.waddr      = cur[UNIT_W-1:0];
            mreq.wdata.hdr  = 1'b1;
            mreq.wdata.free = 1'b0;
            mreq.wdata.size = rdata.size;
            state_next      = S_RESP;
          end
        end else if (walk_next >= CUR_W'(Units)) begin
          status_next = ST_NO_MEM;
          state_next  = S_RESP;
        end else begin
          cur_next   = walk_next;
          state_next = S_AREQ;
        end
      end
      S_AWR: begin
        mreq.we         = 1'b1;
        mreq.waddr      = cur[UNIT_W-1:0];
        mreq.wdata.hdr  = 1'b1;
        mreq.wdata.free = 1'b0;
        mreq.wdata.size = need[UNIT_W-1:0];
        state_next      = S_RESP;
      end
      S_FREQ: state_next = S_FCHK;
      S_FCHK: begin
        cpay = rdata.size;
        if (cur[UNIT_W-1:0] == target) begin
          if (rdata.free) begin
            status_next = ST_DOUBLE;
            state_next  = S_RESP;
          end else if (walk_next >= CUR_W'(Units)) begin
            // last chunk: only a backward merge is possible
            mreq.we         = 1'b1;
            mreq.waddr      = take_prev ? prev_u : cur[UNIT_W-1:0];
            mreq.wdata.hdr  = 1'b1;
            mreq.wdata.free = 1'b1;
            mreq.wdata.size = merged[UNIT_W-1:0];
            state_next      = S_RESP;
          end else begin
            cur_pay_next = rdata.size;
            cur_next     = walk_next;
            state_next   = S_NREQ;
          end
        end else if (walk_next >= CUR_W'(Units)) begin
          status_next = ST_BAD_PTR;
          state_next  = S_RESP;
        end else begin
          has_prev_next  = 1'b1;
          prev_free_next = rdata.free;
          prev_u_next    = cur[UNIT_W-1:0];
          prev_pay_next  = rdata.size;
          cur_next       = walk_next;
          state_next     = S_FREQ;
        end
      end
      S_NREQ: state_next = S_NCHK;
      S_NCHK: begin
        nx_free         = rdata.free;
        mreq.we         = 1'b1;
        mreq.waddr      = take_prev ? prev_u : target;
        mreq.wdata.hdr  = 1'b1;
        mreq.wdata.free = 1'b1;
        mreq.wdata.size = merged[UNIT_W-1:0];
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  assign res_status = status;
  assign res_offset = offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
    cur       <= cur_next;
    need      <= need_next;
    target    <= target_next;
    has_prev  <= has_prev_next;
    prev_free <= prev_free_next;
    prev_u    <= prev_u_next;
    prev_pay  <= prev_pay_next;
    cur_pay   <= cur_pay_next;
    status    <= status_next;
    offset    <= offset_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a 4096-byte arena held as an address-ordered
// chain of chunk headers (24-byte header, 8-byte alignment). One request is
// in flight at a time; for each chunk header visited the walker issues one
// memory read and then checks the header, then writes back up to two
// headers and hands the result to the output register once it has room.
// The header memory gives one read per cycle. After reset the block writes
// the initial free chunk before s_tready rises. The result register frees
// the walker as soon as the result is loaded, so the next request is
// accepted while the last result still waits.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Top level: stream ports, output register, walker and header memory.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // req_size[11:0], free_offset[23:12]
  input  wire logic [1:0]  s_tuser,   // cmd[0], null_pointer[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // status[2:0], alloc_offset[14:3], zero pad
);

  mem_req_t    mreq;
  entry_t      rdata;
  logic        res_valid;
  logic [2:0]  res_status;
  logic [11:0] res_offset;
  logic        slot_free;

  // output slot can take a result when empty or being emptied this cycle
  assign slot_free = !m_tvalid || m_tready;

  ffha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .cmd          (s_tuser[0]),
    .req_size     (s_tdata[11:0]),
    .null_pointer (s_tuser[1]),
    .free_offset  (s_tdata[23:12]),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res_status   (res_status),
    .res_offset   (res_offset),
    .mreq         (mreq),
    .rdata        (rdata)
  );

  ffha_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid) begin
      m_tdata <= {1'b0, res_offset, res_status};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module ffha_checker
  import ffha_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // one request at a time: ready drops right after a transfer
  `FFHA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // status code within the defined set
  `FFHA_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= ST_DOUBLE)
  // failed requests carry no offset
  `FFHA_ASSERT_NOW(a_fail_no_offset, m_tvalid && m_tdata[2:0] != ST_OK, m_tdata[14:3] == 12'd0)
  // stalled result is held
  `FFHA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests over the stream input, predicts each
// status and payload offset with a behavioural chunk-table model, and checks
// every output transfer in order. Random gaps on both sides, one long
// receiver hold-off to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import ffha_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // req_size[11:0], free_offset[23:12]
  logic [1:0]  s_tuser;   // cmd[0], null_pointer[1]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // status[2:0], alloc_offset[14:3], zero pad

  first_fit_heap_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  typedef struct packed {
    logic        cmd;
    logic [11:0] req_size;
    logic        null_ptr;
    logic [11:0] free_offset;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] offset;
  } grant_t;

  // Directed row: request plus, where obvious, the expected outcome.
  typedef struct {
    request_t req;
    int       typed;
    grant_t   res;
  } row_t;

  // Shadow chunk table, one slot per 8-byte unit; sizes in bytes.
  bit          hdr_ok  [Units];
  bit          is_free [Units];
  int unsigned pay_len [Units];

  grant_t   grant_q[$];
  int       live_q[$];   // payload offsets currently held
  int       errors;
  int       idle_cycles;
  bit       all_sent;
  bit       hold_off;

  function automatic bit chunk_at(int unsigned s);
    return s < ArenaBytes && hdr_ok[s / AlignBytes];
  endfunction

  function automatic int unsigned after(int unsigned s);
    return s + HeaderBytes + pay_len[s / AlignBytes];
  endfunction

  task automatic heap_reset();
    for (int i = 0; i < Units; i++) begin
      hdr_ok[i] = 0;
      is_free[i] = 0;
      pay_len[i] = 0;
    end
    hdr_ok[0] = 1;
    is_free[0] = 1;
    pay_len[0] = ArenaBytes - HeaderBytes;
  endtask

  // Applies one request to the shadow table and returns its outcome.
  function automatic grant_t heap_apply(request_t r);
    grant_t      g;
    int unsigned need, cur, prv, nx, nu, u;
    bit          has_prv, found;
    g = '0;
    cur = 0;
    prv = 0;
    has_prv = 0;
    found = 0;
    if (r.cmd == CMD_ALLOC) begin
      if (r.req_size == 0) begin
        g.status = ST_ZERO_SIZE;
        return g;
      end
      need = ((r.req_size + HeaderBytes + AlignBytes - 1) / AlignBytes) * AlignBytes
             - HeaderBytes;
      for (int n = 0; n < Units && chunk_at(cur); n++) begin
        u = cur / AlignBytes;
        if (is_free[u] && pay_len[u] >= need) begin
          if (pay_len[u] >= need + HeaderBytes + 1) begin
            nu = (cur + HeaderBytes + need) / AlignBytes;
            if (nu < Units) begin
              hdr_ok[nu] = 1;
              is_free[nu] = 1;
              pay_len[nu] = pay_len[u] - need - HeaderBytes;
              pay_len[u] = need;
            end
          end
          is_free[u] = 0;
          g.status = ST_OK;
          g.offset = 12'(cur + HeaderBytes);
          return g;
        end
        cur = after(cur);
      end
      g.status = ST_NO_MEM;
      return g;
    end
    if (r.null_ptr) begin
      g.status = ST_NULL_PTR;
      return g;
    end
    if (r.free_offset < HeaderBytes) begin
      g.status = ST_BAD_PTR;
      return g;
    end
    for (int n = 0; n < Units && chunk_at(cur); n++) begin
      if (cur == r.free_offset - HeaderBytes) begin
        found = 1;
        break;
      end
      prv = cur;
      has_prv = 1;
      cur = after(cur);
    end
    if (!found) begin
      g.status = ST_BAD_PTR;
      return g;
    end
    if (is_free[cur / AlignBytes]) begin
      g.status = ST_DOUBLE;
      return g;
    end
    is_free[cur / AlignBytes] = 1;
    // merge backwards, then forwards
    if (has_prv && is_free[prv / AlignBytes]) begin
      pay_len[prv / AlignBytes] += HeaderBytes + pay_len[cur / AlignBytes];
      hdr_ok[cur / AlignBytes] = 0;
      is_free[cur / AlignBytes] = 0;
      pay_len[cur / AlignBytes] = 0;
      cur = prv;
    end
    nx = after(cur);
    if (chunk_at(nx) && is_free[nx / AlignBytes]) begin
      pay_len[cur / AlignBytes] += HeaderBytes + pay_len[nx / AlignBytes];
      hdr_ok[nx / AlignBytes] = 0;
      is_free[nx / AlignBytes] = 0;
      pay_len[nx / AlignBytes] = 0;
    end
    g.status = ST_OK;
    return g;
  endfunction

  function automatic request_t mk(logic c, int sz, int np, int off);
    request_t r;
    r.cmd = c;
    r.req_size = 12'(sz);
    r.null_ptr = 1'(np);
    r.free_offset = 12'(off);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Random request biased toward live pointers so frees actually merge.
  function automatic request_t rand_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      if ($urandom_range(0, 3) == 0) return mk(CMD_ALLOC, $urandom_range(0, 4095),
                                               $urandom_range(0, 1), $urandom);
      return mk(CMD_ALLOC, $urandom_range(1, 200), $urandom_range(0, 1), $urandom);
    end
    if (k < 85 && live_q.size() > 0)
      return mk(CMD_FREE, $urandom, 0, live_q[$urandom_range(0, live_q.size() - 1)]);
    if (k < 90) return mk(CMD_FREE, $urandom, 1, $urandom);
    return mk(CMD_FREE, $urandom, 0, $urandom);
  endfunction

  // Track held pointers from the predicted outcome.
  task automatic note_live(request_t r, grant_t g);
    if (g.status != ST_OK) return;
    if (r.cmd == CMD_ALLOC) live_q.push_back(int'(g.offset));
    else
      foreach (live_q[i])
        if (live_q[i] == r.free_offset) begin
          live_q.delete(i);
          break;
        end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sender: offers one request per transfer, with random gaps. Valid stays
  // up across back-to-back transfers.
  task automatic send(request_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.free_offset, r.req_size};
    s_tuser  <= {r.null_ptr, r.cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic issue(request_t r, int typed, grant_t want);
    grant_t p;
    p = heap_apply(r);
    if (typed != 0 && p !== want) begin
      $display("%0t: table row disagrees, expected %h predicted %h", $time, want, p);
      errors++;
    end
    note_live(r, p);
    grant_q.push_back((typed != 0) ? want : p);
    send(r);
  endtask

  row_t rows[$];

  initial begin
    request_t r;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    errors   = 0;
    all_sent = 0;
    heap_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table: fresh arena, extremes and each error code.
    rows.push_back('{mk(CMD_ALLOC, 0, 1, 4095), 1, '{ST_ZERO_SIZE, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 4095, 1, 24), 1, '{ST_NULL_PTR, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 0), 1, '{ST_BAD_PTR, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 23), 1, '{ST_BAD_PTR, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 24), 1, '{ST_DOUBLE, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 4095, 0, 0), 1, '{ST_NO_MEM, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 4072, 0, 0), 1, '{ST_OK, 12'd24}});
    rows.push_back('{mk(CMD_ALLOC, 1, 0, 0), 1, '{ST_NO_MEM, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 24), 1, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 1, 1, 4095), 1, '{ST_OK, 12'd24}});
    rows.push_back('{mk(CMD_ALLOC, 8, 0, 0), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 9, 0, 0), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 100, 0, 0), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 56), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 60), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 24), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 88), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 56), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 3000, 0, 0), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_ALLOC, 1000, 0, 0), 0, '{ST_OK, 12'd0}});
    rows.push_back('{mk(CMD_FREE, 0, 0, 4072), 0, '{ST_OK, 12'd0}});
    foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].res);

    for (int n = 0; n < 1000; n++) begin
      r = rand_req();
      issue(r, 0, '0);
    end
    s_tvalid <= 1'b0;
    all_sent = 1;
  end

  // Receiver: random stalls, plus one long hold-off early on.
  initial begin
    int g;
    m_tready <= 1'b0;
    hold_off = 0;
    @(negedge rst);
    repeat (60) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
    forever begin
      m_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // Output check against the oldest prediction.
  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual status %0d offset %0d",
                 $time, m_tdata[2:0], m_tdata[14:3]);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[14:3] !== want.offset) begin
          $display("%0t: offset expected %0d actual %0d", $time, want.offset, m_tdata[14:3]);
          errors++;
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (all_sent && grant_q.size() == 0) begin
        repeat (50) @(posedge clk);
        if (errors == 0 && grant_q.size() == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
